>>> rtl/lbbc_pkg.sv
// ----------------------------------------------------------------------------
// lbbc_pkg: shared types and constants of the byte-budget LRU cache
// Command codes, result status codes, sequencer states and the row-control
// struct that the sequencer broadcasts to every cell of the table.
// ----------------------------------------------------------------------------
package lbbc_pkg;

   localparam int CMD_BITS   = 3;
   localparam int SIZE_BITS  = 25;
   localparam int SLOT_BITS  = 4;
   localparam int CNT_BITS   = 5;
   localparam int STAT_BITS  = 32;
   localparam int KEY_PORT   = 64;

   localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_INVAL  = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_STATS  = 3'd4;
   // unassigned codes, answered like a statistics read
   localparam logic [CMD_BITS-1:0] CMD_SPARE5 = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_SPARE7 = 3'd7;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_ZERO  = 2'd1;
   localparam logic [1:0] STATUS_LARGE = 2'd2;

   localparam logic [SIZE_BITS-1:0] CAP_RESET = 25'd65536;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EVICT,
      ST_PLACE,
      ST_FINAL,
      ST_WAIT
   } state_type;

   // Row operation broadcast to all cells.
   typedef enum logic [2:0] {
      ROW_NONE,
      ROW_TOUCH,
      ROW_REMOVE,
      ROW_WRITE
   } row_op_type;

   typedef struct packed {
      row_op_type op;
      logic [5:0] sel;     // target cell index
      logic [5:0] rank;    // rank of target before the operation
   } row_ctl_type;

endpackage

>>> rtl/lbbc_if.sv
// ----------------------------------------------------------------------------
// lbbc_req_if / lbbc_rsp_if: request and response channels
// Valid/ready handshake carrying one request or one response.
// ----------------------------------------------------------------------------
interface lbbc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [63:0] key;
   logic [24:0] entry_size;
   modport source (output valid, command, key, entry_size, input ready);
   modport sink   (input valid, command, key, entry_size, output ready);
endinterface

interface lbbc_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] out_key;
   logic [24:0] entry_bytes;
   logic [3:0]  slot;
   logic        found;
   logic [1:0]  status;
   logic [31:0] hit_count;
   logic [31:0] miss_count;
   logic [24:0] used_bytes;
   logic [4:0]  entry_count;
   logic        last;
   modport source (output valid, kind, out_key, entry_bytes, slot, found, status,
                   hit_count, miss_count, used_bytes, entry_count, last,
                   input ready);
   modport sink   (input valid, kind, out_key, entry_bytes, slot, found, status,
                   hit_count, miss_count, used_bytes, entry_count, last,
                   output ready);
endinterface

>>> rtl/lbbc_cell.sv
// ----------------------------------------------------------------------------
// lbbc_cell: one table slot
// Holds key, size, valid and recency rank; compares its key and rank with
// the broadcast probe and applies the row operation. The top level picks
// the lowest-numbered cell among those that match.
// ----------------------------------------------------------------------------
module lbbc_cell
   import lbbc_pkg::*;
#(
   parameter int KEY_BITS = 64,
   parameter int IDX      = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  row_ctl_type         ctl,
   input  logic [KEY_BITS-1:0] wr_key,
   input  logic [SIZE_BITS-1:0] wr_size,
   input  logic [KEY_BITS-1:0] probe_key,
   input  logic [5:0]          probe_rank,
   input  logic                clear_all,
   output logic                key_hit,
   output logic                rank_hit,
   output logic                valid,
   output logic [KEY_BITS-1:0] key_q,
   output logic [SIZE_BITS-1:0] size_q,
   output logic [5:0]          rank_q
);

   logic [KEY_BITS-1:0]  key_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [5:0]           rank_ff, rank_in;
   logic                 valid_ff, valid_in;
   logic                 me;

   assign me = (ctl.sel == 6'(IDX));

   always_comb begin
      rank_in  = rank_ff;
      valid_in = valid_ff;
      case (ctl.op)
         ROW_TOUCH: begin
            if (me) rank_in = '0;
            else if (valid_ff && rank_ff < ctl.rank) rank_in = rank_ff + 6'd1;
         end
         ROW_REMOVE: begin
            if (me) valid_in = 1'b0;
            else if (valid_ff && rank_ff > ctl.rank) rank_in = rank_ff - 6'd1;
         end
         ROW_WRITE: begin
            if (me) begin
               valid_in = 1'b1;
               rank_in  = '0;
            end else if (valid_ff) rank_in = rank_ff + 6'd1;
         end
         default: ;
      endcase
      if (clear_all) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
      if (ctl.op == ROW_WRITE && me) begin
         key_ff  <= wr_key;
         size_ff <= wr_size;
      end
   end

   assign key_hit  = valid_ff && key_ff == probe_key;
   assign rank_hit = valid_ff && rank_ff == probe_rank;
   assign valid    = valid_ff;
   assign key_q    = key_ff;
   assign size_q   = size_ff;
   assign rank_q   = rank_ff;

endmodule

>>> rtl/lru_byte_budget_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_byte_budget_cache_unit: LRU cache table with a byte budget
// A row of slot cells is probed by key or by rank; a sequencer issues one
// row operation per cycle unless stalled, and emits one response per removed entry.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | command, key, entry_size
//  rsp     | out | valid/ready   | kind, out_key, entry_bytes, slot, found, ...
//  csr     | in  | write enable  | byte budget
//
//  A request is matched in the cycle after acceptance. The final response is
//  registered in the final state, reached straight from the match for lookup,
//  statistics and rejected inserts, through the evict state for invalidate
//  and clear, and through the evict and place states for insert. The next
//  request is taken once the final response is delivered and the sequencer is
//  idle again. The remover retires one entry per cycle unless rsp stalls.
//  Reset clears all valid bits and counters and sets the capacity to 65536.
//  A stalled response holds the sequencer in place.
// ----------------------------------------------------------------------------
module lru_byte_budget_cache_unit
   import lbbc_pkg::*;
#(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   lbbc_req_if.sink             req,
   lbbc_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [SIZE_BITS-1:0] csr_wdata
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   state_type state_ff, state_in;
   logic [SIZE_BITS-1:0] cap_ff;
   logic [CMD_BITS-1:0]  cmd_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [STAT_BITS-1:0] hits_ff, hits_in, miss_ff, miss_in;
   logic [SIZE_BITS-1:0] used_ff, used_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic                 dup_done_ff, dup_done_in;
   logic                 found_ff, found_in;
   logic [SLOT_BITS-1:0] fslot_ff, fslot_in;
   logic [SIZE_BITS-1:0] fsize_ff, fsize_in;
   logic                 full_done_ff, full_done_in;

   // response register
   logic                 rv_ff, rv_in;
   logic                 rkind_ff, rkind_in, rfound_ff, rfound_in, rlast_ff, rlast_in;
   logic [KEY_PORT-1:0]  rkey_ff, rkey_in;
   logic [SIZE_BITS-1:0] rsize_ff, rsize_in;
   logic [SLOT_BITS-1:0] rslot_ff, rslot_in;
   logic [1:0]           rstat_ff, rstat_in;

   row_ctl_type          ctl;
   logic                 clear_all;
   logic [5:0]           probe_rank;
   logic [ENTRIES-1:0]   khit, rhit, vld;
   logic [KEY_BITS-1:0]  ckey  [ENTRIES];
   logic [SIZE_BITS-1:0] csize [ENTRIES];
   logic [5:0]           crank [ENTRIES];

   genvar g;
   generate
      for (g = 0; g < ENTRIES; g++) begin : g_cell
         lbbc_cell #(.KEY_BITS(KEY_BITS), .IDX(g)) u_cell (
            .clock, .reset, .ctl,
            .wr_key(key_ff), .wr_size(size_ff),
            .probe_key(key_ff), .probe_rank,
            .clear_all,
            .key_hit(khit[g]), .rank_hit(rhit[g]), .valid(vld[g]),
            .key_q(ckey[g]), .size_q(csize[g]), .rank_q(crank[g])
         );
      end
   endgenerate

   // priority encoders over the row
   logic [IW-1:0] kidx, ridx, fidx;
   logic          kany, rany, fany;
   always_comb begin
      kidx = '0; ridx = '0; fidx = '0;
      kany = 1'b0; rany = 1'b0; fany = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (khit[i]) begin kidx = IW'(i); kany = 1'b1; end
         if (rhit[i]) begin ridx = IW'(i); rany = 1'b1; end
         if (!vld[i]) begin fidx = IW'(i); fany = 1'b1; end
      end
   end

   logic [SIZE_BITS:0] need;
   assign need = {1'b0, used_ff} + {1'b0, size_ff};

   // clear walks from most recent, evictions from least recent
   assign probe_rank = (cmd_ff == CMD_CLEAR) ? 6'd0 : 6'(cnt_ff - 7'd1);

   always_comb begin
      state_in     = state_ff;
      hits_in      = hits_ff;
      miss_in      = miss_ff;
      used_in      = used_ff;
      cnt_in       = cnt_ff;
      dup_done_in  = dup_done_ff;
      full_done_in = full_done_ff;
      found_in     = found_ff;
      fslot_in     = fslot_ff;
      fsize_in     = fsize_ff;
      rv_in        = rv_ff && !rsp.ready;
      rkind_in = rkind_ff; rfound_in = rfound_ff; rlast_in = rlast_ff;
      rkey_in  = rkey_ff;  rsize_in  = rsize_ff;  rslot_in = rslot_ff;
      rstat_in = rstat_ff;
      ctl       = '{op: ROW_NONE, sel: '0, rank: '0};
      clear_all = 1'b0;
      req.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req.ready = !rv_ff;
            if (req.valid && !rv_ff) begin
               state_in = ST_MATCH;
               dup_done_in = 1'b0;
               full_done_in = 1'b0;
               found_in = 1'b0;
               fslot_in = '0;
               fsize_in = '0;
            end
         end
         ST_MATCH: begin
            case (cmd_ff)
               CMD_LOOKUP: begin
                  if (kany) begin
                     ctl = '{op: ROW_TOUCH, sel: 6'(kidx), rank: crank[kidx]};
                     hits_in = hits_ff + STAT_BITS'(1);
                     found_in = 1'b1;
                     fslot_in = SLOT_BITS'(kidx);
                     fsize_in = csize[kidx];
                  end else miss_in = miss_ff + STAT_BITS'(1);
                  state_in = ST_FINAL;
               end
               CMD_INSERT: begin
                  if (size_ff == '0 || size_ff > cap_ff) state_in = ST_FINAL;
                  else state_in = ST_EVICT;
               end
               CMD_INVAL, CMD_CLEAR: state_in = ST_EVICT;
               default: state_in = ST_FINAL;
            endcase
         end
         ST_EVICT: begin
            if (!rv_ff || rsp.ready) begin
               logic          go;
               logic [IW-1:0] vic;
               go  = 1'b0;
               vic = ridx;
               case (cmd_ff)
                  CMD_INVAL: begin
                     if (kany) begin go = 1'b1; vic = kidx; found_in = 1'b1; end
                     state_in = ST_FINAL;
                  end
                  CMD_CLEAR: begin
                     if (cnt_ff != '0 && rany) go = 1'b1;
                     else state_in = ST_FINAL;
                  end
                  default: begin
                     if (!dup_done_ff) begin
                        dup_done_in = 1'b1;
                        if (kany) begin go = 1'b1; vic = kidx; end
                     end else if (cnt_ff != '0 && need > {1'b0, cap_ff} && rany) begin
                        go = 1'b1;
                     end else if (!full_done_ff && cnt_ff >= 7'(ENTRIES)) begin
                        full_done_in = 1'b1;
                        go = rany;
                     end else state_in = ST_PLACE;
                  end
               endcase
               if (go) begin
                  ctl = '{op: ROW_REMOVE, sel: 6'(vic), rank: crank[vic]};
                  used_in  = used_ff - csize[vic];
                  cnt_in   = cnt_ff - 7'd1;
                  rv_in    = 1'b1;
                  rkind_in = 1'b1;
                  rkey_in  = KEY_PORT'(ckey[vic]);
                  rsize_in = csize[vic];
                  rslot_in = SLOT_BITS'(vic);
                  rfound_in = 1'b0;
                  rstat_in = STATUS_OK;
                  rlast_in = 1'b0;
               end
            end
         end
         ST_PLACE: begin
            if (fany) begin
               ctl = '{op: ROW_WRITE, sel: 6'(fidx), rank: '0};
               used_in  = used_ff + size_ff;
               cnt_in   = cnt_ff + 7'd1;
               fslot_in = SLOT_BITS'(fidx);
            end
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (!rv_ff || rsp.ready) begin
               rv_in    = 1'b1;
               rkind_in = 1'b0;
               rkey_in  = KEY_PORT'(key_ff);
               rsize_in = fsize_ff;
               rslot_in = (cmd_ff == CMD_LOOKUP || cmd_ff == CMD_INSERT) ? fslot_ff : '0;
               rfound_in = found_ff;
               rstat_in = STATUS_OK;
               if (cmd_ff == CMD_INSERT && size_ff == '0) rstat_in = STATUS_ZERO;
               else if (cmd_ff == CMD_INSERT && size_ff > cap_ff) rstat_in = STATUS_LARGE;
               rlast_in = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!rv_ff || rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cap_ff   <= CAP_RESET;
         hits_ff  <= '0;
         miss_ff  <= '0;
         used_ff  <= '0;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) cap_ff <= csr_wdata;
         hits_ff  <= hits_in;
         miss_ff  <= miss_in;
         used_ff  <= used_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
      dup_done_ff  <= dup_done_in;
      full_done_ff <= full_done_in;
      found_ff <= found_in;
      fslot_ff <= fslot_in;
      fsize_ff <= fsize_in;
      rkind_ff <= rkind_in; rfound_ff <= rfound_in; rlast_ff <= rlast_in;
      rkey_ff  <= rkey_in;  rsize_ff  <= rsize_in;  rslot_ff <= rslot_in;
      rstat_ff <= rstat_in;
      if (req.valid && req.ready) begin
         cmd_ff  <= req.command;
         key_ff  <= req.key[KEY_BITS-1:0];
         size_ff <= req.entry_size;
      end
   end

   // response counters report state after the step, so shadow them
   logic [STAT_BITS-1:0] ohits_ff, omiss_ff;
   logic [SIZE_BITS-1:0] oused_ff;
   logic [CNT_BITS-1:0]  ocnt_ff;
   always_ff @(posedge clock) begin
      if (rv_in && !(rv_ff && !rsp.ready)) begin
         ohits_ff <= hits_in;
         omiss_ff <= miss_in;
         oused_ff <= used_in;
         ocnt_ff  <= CNT_BITS'(cnt_in);
      end
   end

   assign rsp.valid       = rv_ff;
   assign rsp.kind        = rkind_ff;
   assign rsp.out_key     = rkey_ff;
   assign rsp.entry_bytes = rsize_ff;
   assign rsp.slot        = rslot_ff;
   assign rsp.found       = rfound_ff;
   assign rsp.status      = rstat_ff;
   assign rsp.hit_count   = ohits_ff;
   assign rsp.miss_count  = omiss_ff;
   assign rsp.used_bytes  = oused_ff;
   assign rsp.entry_count = ocnt_ff;
   assign rsp.last        = rlast_ff;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 7'(ENTRIES)) else $error("entry count above table size");
   a_cnt_match: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 7'($countones(vld))) else $error("entry count drift");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE && !rv_ff) else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp.ready |=> rv_ff && $stable(rkey_ff)) else $error("stalled response lost");
`endif

endmodule

>>> tb/lbbc_tb_if.sv
// ----------------------------------------------------------------------------
// lbbc testbench channel interfaces
// The bench uses the request and response interfaces of the RTL folder
// (lbbc_req_if, lbbc_rsp_if) as they are, so nothing is declared here.
// ----------------------------------------------------------------------------

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: byte-budget LRU cache unit
// Drives a directed table of requests and then random request streams over
// a small key pool, with random idling on both channels. Every response is
// compared field by field against an in-bench LRU table model.
// ----------------------------------------------------------------------------
module testbench
   import lbbc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 16;

   typedef struct packed {
      logic        kind;
      logic [63:0] out_key;
      logic [24:0] entry_bytes;
      logic [3:0]  slot;
      logic        found;
      logic [1:0]  status;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [24:0] used_bytes;
      logic [4:0]  entry_count;
      logic        last;
   } cache_rsp_type;

   typedef struct {
      logic [2:0]    cmd;
      logic [63:0]   key;
      logic [24:0]   size;
      logic          has_want;
      cache_rsp_type want;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [24:0] csr_wdata = '0;
   int error_count = 0;
   bit quiet = 0;

   lbbc_req_if req();
   lbbc_rsp_if rsp();

   lru_byte_budget_cache_unit dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // model state
   logic [63:0]   m_key   [NSLOT];
   logic [24:0]   m_size  [NSLOT];
   bit            m_valid [NSLOT];
   int            m_rank  [NSLOT];
   logic [31:0]   m_hits, m_misses;
   logic [24:0]   m_used, m_cap;
   int            m_count;
   cache_rsp_type expected_rsps[$];
   cache_rsp_type pinned_rsps[$];

   task automatic push_rsp(logic kind, logic [63:0] k, logic [24:0] sz, int s,
                           logic fnd, logic [1:0] st, logic lst);
      cache_rsp_type r;
      r.kind = kind; r.out_key = k; r.entry_bytes = sz; r.slot = s[3:0];
      r.found = fnd; r.status = st; r.hit_count = m_hits;
      r.miss_count = m_misses; r.used_bytes = m_used;
      r.entry_count = m_count[4:0]; r.last = lst;
      expected_rsps.push_back(r);
   endtask

   task automatic drop_slot(int s);
      for (int i = 0; i < NSLOT; i++)
         if (m_valid[i] && m_rank[i] > m_rank[s]) m_rank[i]--;
      m_valid[s] = 0;
      m_used -= m_size[s];
      m_count--;
      push_rsp(1'b1, m_key[s], m_size[s], s, 1'b0, STATUS_OK, 1'b0);
   endtask

   function automatic int slot_of_key(logic [63:0] k);
      for (int i = 0; i < NSLOT; i++)
         if (m_valid[i] && m_key[i] == k) return i;
      return NSLOT;
   endfunction

   function automatic int slot_of_rank(int r);
      for (int i = 0; i < NSLOT; i++)
         if (m_valid[i] && m_rank[i] == r) return i;
      return NSLOT;
   endfunction

   task automatic predict_cache(logic [2:0] cmd, logic [63:0] k, logic [24:0] sz);
      int s;
      case (cmd)
         CMD_LOOKUP: begin
            s = slot_of_key(k);
            if (s < NSLOT) begin
               for (int i = 0; i < NSLOT; i++)
                  if (m_valid[i] && m_rank[i] < m_rank[s]) m_rank[i]++;
               m_rank[s] = 0;
               m_hits++;
               push_rsp(1'b0, k, m_size[s], s, 1'b1, STATUS_OK, 1'b1);
            end else begin
               m_misses++;
               push_rsp(1'b0, k, '0, 0, 1'b0, STATUS_OK, 1'b1);
            end
         end
         CMD_INSERT: begin
            if (sz == 0) push_rsp(1'b0, k, '0, 0, 1'b0, STATUS_ZERO, 1'b1);
            else if (sz > m_cap) push_rsp(1'b0, k, '0, 0, 1'b0, STATUS_LARGE, 1'b1);
            else begin
               s = slot_of_key(k);
               if (s < NSLOT) drop_slot(s);
               while (m_count > 0 && 26'(m_used) + 26'(sz) > 26'(m_cap)) begin
                  s = slot_of_rank(m_count - 1);
                  if (s >= NSLOT) break;
                  drop_slot(s);
               end
               if (m_count >= NSLOT) begin
                  s = slot_of_rank(m_count - 1);
                  if (s < NSLOT) drop_slot(s);
               end
               for (s = 0; s < NSLOT && m_valid[s]; s++) ;
               if (s < NSLOT) begin
                  for (int i = 0; i < NSLOT; i++) if (m_valid[i]) m_rank[i]++;
                  m_valid[s] = 1; m_key[s] = k; m_size[s] = sz; m_rank[s] = 0;
                  m_used += sz; m_count++;
               end else s = 0;
               push_rsp(1'b0, k, '0, s, 1'b0, STATUS_OK, 1'b1);
            end
         end
         CMD_INVAL: begin
            s = slot_of_key(k);
            if (s < NSLOT) drop_slot(s);
            push_rsp(1'b0, k, '0, 0, s < NSLOT, STATUS_OK, 1'b1);
         end
         CMD_CLEAR: begin
            while (m_count > 0) begin
               s = slot_of_rank(0);
               if (s >= NSLOT) break;
               drop_slot(s);
            end
            push_rsp(1'b0, k, '0, 0, 1'b0, STATUS_OK, 1'b1);
         end
         default: push_rsp(1'b0, k, '0, 0, 1'b0, STATUS_OK, 1'b1);
      endcase
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // request driver
   task automatic send_request(logic [2:0] cmd, logic [63:0] k, logic [24:0] sz);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req.valid <= 1'b1; req.command <= cmd; req.key <= k; req.entry_size <= sz;
      do @(posedge clock); while (!req.ready);
      predict_cache(cmd, k, sz);
   endtask

   task automatic go_idle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_capacity(logic [24:0] v);
      go_idle();
      csr_we <= 1'b1; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      m_cap = v;
   endtask

   // response side
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (quiet) rsp.ready <= 1'b1;
      else if (rsp.ready && $urandom_range(0, 4) == 0) rsp.ready <= 1'b0;
      else if (!rsp.ready && $urandom_range(0, 2) == 0) rsp.ready <= 1'b1;
   end

   always @(posedge clock) begin
      cache_rsp_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.kind, rsp.out_key, rsp.entry_bytes, rsp.slot, rsp.found, rsp.status,
                 rsp.hit_count, rsp.miss_count, rsp.used_bytes, rsp.entry_count,
                 rsp.last};
         if (expected_rsps.size() == 0) report_mismatch("unexpected response", 64'd0, 64'd0);
         else begin
            want = expected_rsps.pop_front();
            if (pinned_rsps.size() != 0 && want.last) begin
               if (pinned_rsps[0] != want)
                  report_mismatch("pinned row", want.out_key, pinned_rsps[0].out_key);
               void'(pinned_rsps.pop_front());
            end
            if (got.kind != want.kind)
               report_mismatch("kind", 64'(got.kind), 64'(want.kind));
            if (got.out_key != want.out_key)
               report_mismatch("out_key", got.out_key, want.out_key);
            if (got.entry_bytes != want.entry_bytes)
               report_mismatch("entry_bytes", 64'(got.entry_bytes), 64'(want.entry_bytes));
            if (got.slot != want.slot)
               report_mismatch("slot", 64'(got.slot), 64'(want.slot));
            if (got.found != want.found)
               report_mismatch("found", 64'(got.found), 64'(want.found));
            if (got.status != want.status)
               report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.hit_count != want.hit_count)
               report_mismatch("hit_count", 64'(got.hit_count), 64'(want.hit_count));
            if (got.miss_count != want.miss_count)
               report_mismatch("miss_count", 64'(got.miss_count), 64'(want.miss_count));
            if (got.used_bytes != want.used_bytes)
               report_mismatch("used_bytes", 64'(got.used_bytes), 64'(want.used_bytes));
            if (got.entry_count != want.entry_count)
               report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
            if (got.last != want.last)
               report_mismatch("last", 64'(got.last), 64'(want.last));
         end
      end
   end

   function automatic stim_row_type row(logic [2:0] c, logic [63:0] k, logic [24:0] s);
      row = '{c, k, s, 1'b0, '0};
   endfunction

   function automatic stim_row_type pinned(logic [2:0] c, logic [63:0] k, logic [24:0] s,
                                           logic [1:0] st, logic [31:0] h, logic [31:0] m);
      pinned = '{c, k, s, 1'b1,
                 '{1'b0, k, 25'd0, 4'd0, 1'b0, st, h, m, 25'd0, 5'd0, 1'b1}};
   endfunction

   logic [63:0] key_pool[8];

   initial begin
      stim_row_type directed[$];
      logic [2:0] c;
      logic [63:0] k;
      logic [24:0] sz;

      req.valid = 0; req.command = '0; req.key = '0; req.entry_size = '0;
      for (int i = 0; i < NSLOT; i++) begin
         m_valid[i] = 0; m_rank[i] = 0; m_key[i] = '0; m_size[i] = '0;
      end
      m_hits = 0; m_misses = 0; m_used = 0; m_count = 0; m_cap = CAP_RESET;
      for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0; key_pool[1] = '1;

      directed.push_back(pinned(CMD_STATS, 64'h0, 25'd0, STATUS_OK, 0, 0));
      directed.push_back(pinned(CMD_LOOKUP, '1, 25'd0, STATUS_OK, 0, 1));
      directed.push_back(pinned(CMD_INSERT, 64'h5, 25'd0, STATUS_ZERO, 0, 1));
      directed.push_back(pinned(CMD_INSERT, 64'h6, 25'd65537, STATUS_LARGE, 0, 1));
      directed.push_back(pinned(CMD_INSERT, 64'h7, 25'h1FFFFFF, STATUS_LARGE, 0, 1));
      directed.push_back(row(CMD_INSERT, '1, 25'd65536));
      directed.push_back(row(CMD_INSERT, 64'h0, 25'd1));
      directed.push_back(row(CMD_LOOKUP, '1, 25'h1FFFFFF));
      directed.push_back(row(CMD_LOOKUP, 64'h0, 25'd0));
      directed.push_back(row(CMD_INSERT, 64'h0, 25'd100));
      for (int i = 0; i < 17; i++) directed.push_back(row(CMD_INSERT, 64'h100 + i, 25'd8));
      directed.push_back(row(CMD_LOOKUP, 64'h105, 25'd0));
      directed.push_back(row(CMD_INVAL, 64'h106, 25'd0));
      directed.push_back(row(CMD_INVAL, 64'h106, 25'd0));
      directed.push_back(row(CMD_SPARE5, 64'hA5A5, 25'd3));
      directed.push_back(row(CMD_SPARE7, 64'h5A5A, 25'd0));
      directed.push_back(row(CMD_CLEAR, 64'h1, 25'd0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].has_want) pinned_rsps.push_back(directed[i].want);
         send_request(directed[i].cmd, directed[i].key, directed[i].size);
      end

      // large budget of 2^24 bytes, then a one-byte budget where eviction is constant
      write_capacity(25'h1000000);
      send_request(CMD_INSERT, 64'h9, 25'h1000000);
      send_request(CMD_INSERT, 64'hA, 25'd1);
      write_capacity(25'd1);
      send_request(CMD_INSERT, 64'hB, 25'd1);
      send_request(CMD_INSERT, 64'hB, 25'd2);
      // pause until drained
      go_idle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_capacity(25'd40);
            1: write_capacity(25'd200);
            2: write_capacity(25'($urandom_range(1, 25'h1FFFFFF)));
            default: begin
               write_capacity(25'd120);
               quiet = 1;
            end
         endcase
         for (int j = 0; j < 16; j++) begin
            c = $urandom_range(0, 9) < 4 ? CMD_INSERT : CMD_LOOKUP;
            if ($urandom_range(0, 9) == 0)
               c = 3'($urandom_range(int'(CMD_INVAL), int'(CMD_SPARE7)));
            k = $urandom_range(0, 9) == 0 ? {$urandom, $urandom} : key_pool[$urandom_range(0, 7)];
            sz = phase == 2 ? 25'($urandom) : 25'($urandom_range(0, 40));
            if ($urandom_range(0, 19) == 0) sz = 25'h1FFFFFF;
            send_request(c, k, sz);
         end
      end
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0 && pinned_rsps.size() == 0)
         $display("lru_byte_budget_cache_unit verification clean");
      else
         $display("lru_byte_budget_cache_unit verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("lru_byte_budget_cache_unit verification failed");
      $finish;
   end
endmodule
